FILE: src/bgr2hsv_pkg.sv
// ============================================================================
// bgr2hsv_pkg
// Types, constants and helper functions shared by the BGR to HSV converter.
// ============================================================================
`default_nettype none

package bgr2hsv_pkg;

    // Channel and arithmetic widths.
    localparam int CHAN_W             = 8;
    localparam int NUM_W              = 2 * CHAN_W;
    localparam int DIFF_W             = CHAN_W + 1;
    localparam int PROD_DIFF_W        = 15;
    localparam int PROD_BASE_W        = NUM_W + 1;

    // Divider pipeline: quotient bits resolved per stage and stage count.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = CHAN_W / DIV_BITS_PER_STAGE;

    // Hue constants in two-degree units.
    localparam logic [CHAN_W-1:0] HUE_HALF_SECTOR = 8'd30;
    localparam logic [CHAN_W-1:0] HUE_GREEN_BASE  = 8'd60;
    localparam logic [CHAN_W-1:0] HUE_BLUE_BASE   = 8'd120;
    localparam logic [CHAN_W-1:0] HUE_WRAP        = 8'd180;
    localparam logic [CHAN_W-1:0] FULL_SCALE      = 8'd255;

    // Input and output payloads.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } t_hsv;

    // Hue sector selected by the channel that holds the maximum.
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_RED_WRAP,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    // Front stage: extrema, sector and signed channel difference.
    typedef struct packed {
        logic                     valid;
        logic [CHAN_W-1:0]        mx;
        logic [CHAN_W-1:0]        d;
        t_sector                  sector;
        logic signed [DIFF_W-1:0] diff;
    } t_front;

    // One slot of the divider pipeline; both divisions travel together.
    typedef struct packed {
        logic              valid;
        logic [NUM_W-1:0]  hrem;
        logic [NUM_W-1:0]  srem;
        logic [CHAN_W-1:0] hq;
        logic [CHAN_W-1:0] sq;
        logic [CHAN_W-1:0] d;
        logic [CHAN_W-1:0] mx;
    } t_div_slot;

    // Result of one restoring division step.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic             qbit;
    } t_div_step;

    // Base hue of a sector.
    function automatic logic [CHAN_W-1:0] sector_base(input t_sector sec);
        logic [CHAN_W-1:0] base;
        unique case (sec)
            SECT_RED:      base = '0;
            SECT_RED_WRAP: base = HUE_WRAP;
            SECT_GREEN:    base = HUE_GREEN_BASE;
            SECT_BLUE:     base = HUE_BLUE_BASE;
            default:       base = '0;
        endcase
        return base;
    endfunction

    // One restoring step: try to subtract the divisor shifted by pos.
    function automatic t_div_step div_step(
        input logic [NUM_W-1:0]  rem,
        input logic [CHAN_W-1:0] den,
        input logic [2:0]        pos
    );
        t_div_step        res;
        logic [NUM_W-1:0] dsh;
        dsh = NUM_W'(den) << pos;
        if (rem >= dsh) begin
            res.rem  = rem - dsh;
            res.qbit = 1'b1;
        end else begin
            res.rem  = rem;
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/bgr_to_hsv_pixel_converter_unit.sv
// ============================================================================
// bgr_to_hsv_pixel_converter_unit
// Converts one 8-bit BGR pixel per clock into its 8-bit HSV form.
//
// Usage: a transaction enters when i_start is high and o_busy is low; o_busy
// is always low, so a pixel can be offered on every clock. Each result
// appears on o_hsv for exactly one cycle with o_valid high, after the pixel
// has passed every register stage, in the order the pixels came in. Throughput
// is one pixel per cycle. The pipeline has six register stages: extrema and
// sector, constant-multiply numerators, then four divider stages that each
// resolve two quotient bits of both the hue and the saturation division.
// The receiver cannot stall: it must take each result in its cycle.
// A synchronous reset clears all valid bits, dropping pixels in flight;
// data registers are not reset.
// Gray pixels give hue 0 and black pixels give saturation 0.
// ============================================================================
`default_nettype none

module bgr_to_hsv_pixel_converter_unit
    import bgr2hsv_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_pixel i_pixel,
    output logic        o_busy,
    output logic        o_valid,
    output t_hsv        o_hsv
);

    t_front    r_front, n_front;
    t_div_slot n_numer;
    t_div_slot r_slot [0:DIV_STAGES];
    t_div_slot n_slot [0:DIV_STAGES];

    // The pipeline never holds off a transaction.
    assign o_busy = 1'b0;

    // Stage 1: maximum, minimum, delta and hue sector.
    always_comb begin
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] mn;
        mx = i_pixel.blue;
        mn = i_pixel.blue;
        if (i_pixel.green > mx) mx = i_pixel.green;
        if (i_pixel.red > mx)   mx = i_pixel.red;
        if (i_pixel.green < mn) mn = i_pixel.green;
        if (i_pixel.red < mn)   mn = i_pixel.red;

        n_front.valid = i_start & ~o_busy;
        n_front.mx    = mx;
        n_front.d     = mx - mn;

        // Red wins ties, then green over blue.
        priority if (mx == i_pixel.red) begin
            n_front.sector = (i_pixel.green >= i_pixel.blue) ? SECT_RED : SECT_RED_WRAP;
            n_front.diff   = $signed({1'b0, i_pixel.green}) - $signed({1'b0, i_pixel.blue});
        end else if (mx == i_pixel.green) begin
            n_front.sector = SECT_GREEN;
            n_front.diff   = $signed({1'b0, i_pixel.blue}) - $signed({1'b0, i_pixel.red});
        end else begin
            n_front.sector = SECT_BLUE;
            n_front.diff   = $signed({1'b0, i_pixel.red}) - $signed({1'b0, i_pixel.green});
        end
    end

    // Stage 2: hue and saturation numerators by constant multiplication.
    always_comb begin
        logic [PROD_BASE_W-1:0]        prod_base;
        logic signed [PROD_DIFF_W-1:0] prod_diff;
        logic signed [PROD_BASE_W:0]   hsum;
        prod_base = PROD_BASE_W'(sector_base(r_front.sector)) * PROD_BASE_W'(r_front.d);
        prod_diff = PROD_DIFF_W'(r_front.diff) * $signed({1'b0, HUE_HALF_SECTOR});
        hsum      = $signed({1'b0, prod_base}) + (PROD_BASE_W + 1)'(prod_diff);

        n_numer.valid = r_front.valid;
        n_numer.hrem  = hsum[NUM_W-1:0];
        n_numer.srem  = NUM_W'(FULL_SCALE) * NUM_W'(r_front.d);
        n_numer.hq    = '0;
        n_numer.sq    = '0;
        n_numer.d     = r_front.d;
        n_numer.mx    = r_front.mx;
    end

    // Divider stages: each resolves two quotient bits, most significant first.
    always_comb begin
        t_div_step hs;
        t_div_step ss;
        n_slot[0] = n_numer;
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_slot[k+1] = r_slot[k];
            for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
                hs = div_step(n_slot[k+1].hrem, r_slot[k].d,
                              3'(CHAN_W - 1 - DIV_BITS_PER_STAGE * k - j));
                ss = div_step(n_slot[k+1].srem, r_slot[k].mx,
                              3'(CHAN_W - 1 - DIV_BITS_PER_STAGE * k - j));
                n_slot[k+1].hrem = hs.rem;
                n_slot[k+1].srem = ss.rem;
                n_slot[k+1].hq   = {n_slot[k+1].hq[CHAN_W-2:0], hs.qbit};
                n_slot[k+1].sq   = {n_slot[k+1].sq[CHAN_W-2:0], ss.qbit};
            end
        end
    end

    // Pipeline registers: valid bits are cleared by reset, data loads every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_slot[k].valid <= 1'b0;
            end
        end else begin
            r_front.valid <= n_front.valid;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_slot[k].valid <= n_slot[k].valid;
            end
        end
        r_front.mx     <= n_front.mx;
        r_front.d      <= n_front.d;
        r_front.sector <= n_front.sector;
        r_front.diff   <= n_front.diff;
        for (int k = 0; k <= DIV_STAGES; k++) begin
            r_slot[k].hrem <= n_slot[k].hrem;
            r_slot[k].srem <= n_slot[k].srem;
            r_slot[k].hq   <= n_slot[k].hq;
            r_slot[k].sq   <= n_slot[k].sq;
            r_slot[k].d    <= n_slot[k].d;
            r_slot[k].mx   <= n_slot[k].mx;
        end
    end

    // Output: gray and black pixels override the division by zero.
    assign o_valid          = r_slot[DIV_STAGES].valid;
    assign o_hsv.hue        = (r_slot[DIV_STAGES].d == '0) ? '0 : r_slot[DIV_STAGES].hq;
    assign o_hsv.saturation = (r_slot[DIV_STAGES].mx == '0) ? '0 : r_slot[DIV_STAGES].sq;
    assign o_hsv.brightness = r_slot[DIV_STAGES].mx;

`ifndef NO_ASSERTIONS
    // A result only follows an accepted transaction, one pipeline depth earlier.
    a_latency: assert property (@(posedge i_clk)
        o_valid |-> $past(i_start, DIV_STAGES + 2))
        else $error("result without a matching transaction");

    // Hue stays inside its two-degree range.
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hsv.hue < HUE_WRAP))
        else $error("hue out of range");

    // The hue division leaves a remainder below the divisor.
    a_hue_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot[DIV_STAGES].valid && (r_slot[DIV_STAGES].d != '0)) |->
        (r_slot[DIV_STAGES].hrem < NUM_W'(r_slot[DIV_STAGES].d)))
        else $error("hue division remainder too large");

    // The saturation division leaves a remainder below the divisor.
    a_sat_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot[DIV_STAGES].valid && (r_slot[DIV_STAGES].mx != '0)) |->
        (r_slot[DIV_STAGES].srem < NUM_W'(r_slot[DIV_STAGES].mx)))
        else $error("saturation division remainder too large");

    // A black pixel has neither hue nor saturation.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_hsv.brightness == '0)) |->
        ((o_hsv.saturation == '0) && (o_hsv.hue == '0)))
        else $error("black pixel with hue or saturation");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_bgr_to_hsv_pixel_converter_unit.sv
// ============================================================================
// tb_bgr_to_hsv_pixel_converter_unit
// Self-checking testbench for the BGR to HSV pixel converter. A directed table
// covers black, white, gray, the primaries, tied maxima and the wrapped red
// sector; random pixels follow. Every result is compared field by field, in
// arrival order, with a hand-typed value or an independent integer HSV model.
// ============================================================================

module tb_bgr_to_hsv_pixel_converter_unit;
    import bgr2hsv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 1350;
    localparam int MAX_GAP       = 11;
    localparam int DRAIN_CYCLES  = 16;

    // Hue arithmetic in two-degree units.
    localparam int HALF_SECTOR = 30;
    localparam int GREEN_BASE  = 60;
    localparam int BLUE_BASE   = 120;
    localparam int WRAP_HUE    = 180;
    localparam int FULL_RANGE  = 255;

    // One row of the directed table; known marks a hand-typed expectation.
    typedef struct packed {
        t_pixel px;
        logic   known;
        t_hsv   hsv;
    } t_dir_row;

    // A pixel in flight and the HSV value it should produce.
    typedef struct {
        t_pixel px;
        t_hsv   hsv;
    } t_pending;

    localparam int DIR_ROWS = 23;
    // Fields are {blue, green, red} and {hue, saturation, brightness}.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},   // black
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0,   8'd0,   8'd255}}, // white
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd0,   8'd0,   8'd128}}, // mid gray
        '{'{8'd1,   8'd1,   8'd1},   1'b1, '{8'd0,   8'd0,   8'd1}},   // darkest gray
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd0,   8'd255, 8'd255}}, // red
        '{'{8'd0,   8'd255, 8'd0},   1'b1, '{8'd60,  8'd255, 8'd255}}, // green
        '{'{8'd255, 8'd0,   8'd0},   1'b1, '{8'd120, 8'd255, 8'd255}}, // blue
        '{'{8'd0,   8'd0,   8'd1},   1'b1, '{8'd0,   8'd255, 8'd1}},   // dimmest red
        '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{8'd30,  8'd255, 8'd255}}, // yellow
        '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{8'd150, 8'd255, 8'd255}}, // magenta
        '{'{8'd255, 8'd255, 8'd0},   1'b1, '{8'd90,  8'd255, 8'd255}}, // cyan
        '{'{8'd254, 8'd0,   8'd255}, 1'b0, '0},
        '{'{8'd1,   8'd0,   8'd255}, 1'b0, '0},
        '{'{8'd0,   8'd1,   8'd255}, 1'b0, '0},
        '{'{8'd254, 8'd254, 8'd255}, 1'b0, '0},
        '{'{8'd200, 8'd100, 8'd201}, 1'b0, '0},
        '{'{8'd201, 8'd100, 8'd200}, 1'b0, '0},
        '{'{8'd100, 8'd200, 8'd200}, 1'b0, '0},
        '{'{8'd200, 8'd200, 8'd100}, 1'b0, '0},
        '{'{8'd0,   8'd128, 8'd255}, 1'b0, '0},
        '{'{8'd170, 8'd85,  8'd0},   1'b0, '0},
        '{'{8'd85,  8'd170, 8'd255}, 1'b0, '0},
        '{'{8'd127, 8'd3,   8'd2},   1'b0, '0}
    };

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_start;
    t_pixel i_pixel;
    logic   o_busy;
    logic   o_valid;
    t_hsv   o_hsv;

    // Expectation that travels with the pixel currently offered.
    t_hsv     offered_hsv;
    t_pending pending_q [$];
    int       pixels_sent;
    int       results_checked;
    int       error_count;
    bit       no_gaps;

    bgr_to_hsv_pixel_converter_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_pixel (i_pixel),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_hsv   (o_hsv)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Integer HSV conversion: floor division throughout, red sector first.
    function automatic t_hsv hsv_of_pixel(input t_pixel px);
        int   b, g, r, top, bottom, span, num;
        t_hsv res;
        b      = px.blue;
        g      = px.green;
        r      = px.red;
        top    = (b > g) ? b : g;
        top    = (r > top) ? r : top;
        bottom = (b < g) ? b : g;
        bottom = (r < bottom) ? r : bottom;
        span   = top - bottom;
        res.brightness = 8'(top);
        res.saturation = (top == 0) ? 8'd0 : 8'((FULL_RANGE * span) / top);
        if (span == 0) begin
            num = 0;
        end else if (top == r) begin
            // A negative red-sector hue wraps around to the top of the range.
            num = (g >= b) ? HALF_SECTOR * (g - b)
                           : WRAP_HUE * span - HALF_SECTOR * (b - g);
        end else if (top == g) begin
            num = GREEN_BASE * span + HALF_SECTOR * (b - r);
        end else begin
            num = BLUE_BASE * span + HALF_SECTOR * (r - g);
        end
        res.hue = (span == 0) ? 8'd0 : 8'(num / span);
        return res;
    endfunction

    // Channel value picked from the ends and the middle of the range.
    function automatic logic [CHAN_W-1:0] edge_channel();
        logic [CHAN_W-1:0] picks [6];
        picks = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        return picks[$urandom_range(0, 5)];
    endfunction

    // Offers one pixel after a random idle gap, or none in full-rate bursts, and holds it until taken.
    task automatic send_pixel(input t_pixel px, input t_hsv want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_start <= 1'b0;
            i_pixel <= t_pixel'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_start     <= 1'b1;
        i_pixel     <= px;
        offered_hsv <= want;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Record accepted pixels and check each result against the oldest one.
    always @(posedge i_clk) begin
        t_pending head;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                pending_q.push_back('{i_pixel, offered_hsv});
            end
            if (o_valid !== 1'b0) begin
                if (pending_q.size() == 0) begin
                    $display("%0t: unexpected result h=%0d s=%0d v=%0d", $realtime,
                             o_hsv.hue, o_hsv.saturation, o_hsv.brightness);
                    error_count++;
                end else begin
                    head = pending_q.pop_front();
                    results_checked++;
                    if (o_hsv.hue !== head.hsv.hue
                            || o_hsv.saturation !== head.hsv.saturation
                            || o_hsv.brightness !== head.hsv.brightness) begin
                        $display({"%0t: pixel b=%0d g=%0d r=%0d expected h=%0d s=%0d v=%0d,",
                                  " got h=%0d s=%0d v=%0d"}, $realtime,
                                 head.px.blue, head.px.green, head.px.red,
                                 head.hsv.hue, head.hsv.saturation, head.hsv.brightness,
                                 o_hsv.hue, o_hsv.saturation, o_hsv.brightness);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, then shaped random pixels.
    initial begin
        t_pixel px;
        logic [CHAN_W-1:0] level;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_pixel         = '0;
        offered_hsv     = '0;
        pixels_sent     = 0;
        results_checked = 0;
        error_count     = 0;
        no_gaps         = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < DIR_ROWS; row++) begin
            send_pixel(DIR_TABLE[row].px, DIR_TABLE[row].known ? DIR_TABLE[row].hsv
                                                               : hsv_of_pixel(DIR_TABLE[row].px));
        end

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            // Switch between gapped traffic and full-rate bursts now and then.
            if (n % 50 == 0) begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            px = t_pixel'($urandom);
            level = px.red;
            case ($urandom_range(0, 9))
                5: px = '{level, level, level};
                6: begin
                    case ($urandom_range(0, 2))
                        0: px.green = px.red;
                        1: px.blue  = px.red;
                        default: px.blue = px.green;
                    endcase
                end
                7: px = '{edge_channel(), edge_channel(), edge_channel()};
                8: begin
                    px.red   = 8'd255;
                    px.green = 8'd0;
                    px       = t_pixel'({px} >> (CHAN_W * $urandom_range(0, 1)))
                             | (px.blue & {CHAN_W{1'b0}});
                end
                9: px = '{8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                          8'($urandom_range(0, 3))};
                default: ;
            endcase
            send_pixel(px, hsv_of_pixel(px));
        end
        i_start <= 1'b0;

        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb summary: %0d pixels sent, %0d results checked, %0d mismatches",
                 pixels_sent, results_checked, error_count);
        $display("tb summary: covered gray, black, primaries, tied maxima and hue wrap");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog against a stalled pipeline.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
